FILE: hw/rtl/lpr_pkg.sv
// Package for the ordered identifier list: command and status codes,
// field widths, the per-cell control word and default sizing.
// Depends on nothing; every file of the block imports it.
package lpr_pkg;

   localparam int ID_W             = 16;
   localparam int CMD_W            = 2;
   localparam int STATUS_W         = 2;
   localparam int COUNT_OUT_W      = 5;
   localparam int CAPACITY_DEFAULT = 16;

   typedef enum logic [CMD_W-1:0] {
      OP_PUSH    = 2'd0,
      OP_POP     = 2'd1,
      OP_REPLACE = 2'd2,
      OP_NONE    = 2'd3
   } lpr_op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } lpr_status_type;

   typedef logic [ID_W-1:0] lpr_id_type;

   // Control word broadcast to one cell of the chain.
   typedef struct packed {
      lpr_op_type op;
      logic       valid;   // cell holds a live entry
      logic       load;    // cell is the next free slot
   } lpr_cell_ctl_type;

endpackage

FILE: hw/rtl/lpr_cell.sv
// One slot of the identifier chain: holds a word, shifts it towards the
// oldest end on pop, loads on push and rewrites on a newest-first match.
// Depends on lpr_pkg.
module lpr_cell (
   input  logic                      clock,
   input  lpr_pkg::lpr_cell_ctl_type ctl,
   input  lpr_pkg::lpr_id_type       stop_id,
   input  lpr_pkg::lpr_id_type       new_id,
   input  lpr_pkg::lpr_id_type       next_data,
   input  logic                      found_in,
   output lpr_pkg::lpr_id_type       data,
   output logic                      found_out
);
   import lpr_pkg::*;

   lpr_id_type data_ff;
   lpr_id_type data_in;
   logic       match;

   assign match     = ctl.valid && (data_ff == stop_id);
   assign found_out = found_in || match;
   assign data      = data_ff;

   always_comb begin
      data_in = data_ff;
      case (ctl.op)
         OP_PUSH: begin
            if (ctl.load) begin
               data_in = stop_id;
            end
         end
         OP_POP: begin
            data_in = next_data;
         end
         OP_REPLACE: begin
            // only the newest match takes the new word
            if (match && !found_in) begin
               data_in = new_id;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

FILE: hw/rtl/list_push_front_pop_back_replace.sv
// Ordered identifier list: a chain of lpr_cell slots plus occupancy count.
// Depends on lpr_pkg and lpr_cell.
//
// Usage:
//   Present a command on req_cmd, req_stop_id and req_new_id with start
//   high; it is taken at the rising edge where start is high and busy is
//   low. busy never rises, so a command may be given in every cycle.
//   Commands: push appends req_stop_id at the newest end, pop drops the
//   oldest entry, replace overwrites the newest entry equal to req_stop_id
//   with req_new_id; the unused code is ignored and answers ok.
//   Each command gives one result word (rsp_status, rsp_entry_count) with
//   rsp_valid high for exactly one cycle, the cycle after the command is
//   taken. Throughput is one command per cycle: every
//   slot compares, shifts or loads in parallel, and the replace search is a
//   one-bit found flag passed from the newest slot to the oldest, so the
//   clock period grows with CAPACITY.
//   The receiver cannot stall; results are not held.
//   Synchronous reset empties the list (count zero) and clears rsp_valid;
//   slot contents are left as they are and are never read while unused.
module list_push_front_pop_back_replace #(
   parameter int CAPACITY = lpr_pkg::CAPACITY_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [lpr_pkg::CMD_W-1:0]        req_cmd,
   input  logic [lpr_pkg::ID_W-1:0]         req_stop_id,
   input  logic [lpr_pkg::ID_W-1:0]         req_new_id,
   output logic                             rsp_valid,
   output logic [lpr_pkg::STATUS_W-1:0]     rsp_status,
   output logic [lpr_pkg::COUNT_OUT_W-1:0]  rsp_entry_count
);
   import lpr_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [CNT_W-1:0]           count_ff;
   logic [CNT_W-1:0]           count_in;
   logic                       rsp_valid_ff;
   lpr_status_type             rsp_status_ff;
   lpr_status_type             status_in;
   logic [COUNT_OUT_W-1:0]     rsp_count_ff;
   logic [CNT_W+COUNT_OUT_W-1:0] count_wide;

   logic                       accept;
   lpr_op_type                 op;
   logic                       is_empty;
   logic                       is_full;

   lpr_cell_ctl_type           cell_ctl [CAPACITY];
   lpr_id_type                 cell_data [CAPACITY];
   logic                       cell_found [CAPACITY];

   assign busy     = 1'b0;
   assign accept   = start && !busy;
   assign op       = accept ? lpr_op_type'(req_cmd) : OP_NONE;
   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff == CNT_W'(CAPACITY));

   genvar i;
   generate
      for (i = 0; i < CAPACITY; i++) begin : g_cell
         logic       found_from_newer;
         lpr_id_type data_from_newer;

         assign cell_ctl[i].op    = op;
         assign cell_ctl[i].valid = (CNT_W'(i) < count_ff);
         assign cell_ctl[i].load  = (CNT_W'(i) == count_ff);

         if (i == CAPACITY - 1) begin : g_top
            assign found_from_newer = 1'b0;
            assign data_from_newer  = cell_data[i];
         end else begin : g_mid
            assign found_from_newer = cell_found[i+1];
            assign data_from_newer  = cell_data[i+1];
         end

         lpr_cell u_cell (
            .clock     (clock),
            .ctl       (cell_ctl[i]),
            .stop_id   (req_stop_id),
            .new_id    (req_new_id),
            .next_data (data_from_newer),
            .found_in  (found_from_newer),
            .data      (cell_data[i]),
            .found_out (cell_found[i])
         );
      end
   endgenerate

   always_comb begin
      count_in  = count_ff;
      status_in = ST_OK;
      case (op)
         OP_PUSH: begin
            if (is_full) begin
               status_in = ST_FULL;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_POP: begin
            if (is_empty) begin
               status_in = ST_EMPTY;
            end else begin
               count_in = count_ff - CNT_W'(1);
            end
         end
         OP_REPLACE: begin
            status_in = cell_found[0] ? ST_OK : ST_NOT_FOUND;
         end
         default: begin
         end
      endcase
   end

   // report the low bits of the count after the command
   assign count_wide = (CNT_W+COUNT_OUT_W)'(count_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= status_in;
      rsp_count_ff  <= count_wide[COUNT_OUT_W-1:0];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;

   a_rsp_follows_cmd : assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("command taken without a result word next cycle");

   a_no_spurious_rsp : assert property (@(posedge clock) disable iff (reset)
      !accept |=> !rsp_valid)
      else $error("result word without a command");

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("occupancy beyond capacity");

   a_count_idle : assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(count_ff))
      else $error("occupancy moved without a command");

   a_full_only_when_full : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_FULL) |-> count_ff == CNT_W'(CAPACITY))
      else $error("full reported while slots are free");

endmodule
